/* src/uvc_pkg.sv */
// shared types and constants for the unused vertex compaction block
`default_nettype none

package uvc_pkg;

    // default number of vertex slots in the table
    localparam int VERTEX_SLOTS_DEF = 4096;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int VIDX_W  = 16;
    localparam int NIDX_W  = 12;
    localparam int TOTAL_W = 13;

    // padded stream widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_START   = 2'd0,
        CMD_MARK    = 2'd1,
        CMD_COMPACT = 2'd2,
        CMD_REMAP   = 2'd3
    } cmd_t;

    // one table word: used mark plus remap entry
    typedef struct packed {
        logic              mark;
        logic              dropped;
        logic [NIDX_W-1:0] idx;
    } entry_t;

    // one result item
    typedef struct packed {
        logic               status;
        logic [TOTAL_W-1:0] kept_total;
        logic               move_needed;
        logic               index_unused;
        logic [NIDX_W-1:0]  new_index;
    } result_t;

endpackage

`default_nettype wire

/* src/unused_vertex_compaction.sv */
// unused vertex compaction: mark, compact and remap over one table memory
//
// Usage: requests enter on the s_axis channel (cmd, vertex_index) and one
// result per request leaves on the m_axis channel (new_index, index_unused,
// move_needed, kept_total, status). START clears the kept counter, MARK sets
// the used mark of a vertex, COMPACT is sent once per old vertex and hands
// out the next dense index, REMAP looks up the new index of a vertex.
// A request passes the synchronous table read, then the update that also
// loads the output register.
// Throughput is one request per cycle while the receiver keeps up; the table
// memory is read in the accept cycle and written back as the request leaves
// the update stage, and a write-back register forwards the newest entry to a
// following request on the same vertex. After reset a clearing pass zeroes
// the table, one entry per cycle; s_tready is low during it.
// When the receiver stalls, the result waits in the output register, one more
// request waits in the update stage, and s_tready drops until space frees.
`default_nettype none

module unused_vertex_compaction #(
    parameter int VERTEX_SLOTS = uvc_pkg::VERTEX_SLOTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request: [1:0] cmd, [17:2] vertex_index, [23:18] zero
    input  wire logic [uvc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // result: [11:0] new_index, [12] index_unused, [13] move_needed,
    // [26:14] kept_total, [27] status, [31:28] zero
    output logic [uvc_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready
);

    localparam int AW = $clog2(VERTEX_SLOTS);
    localparam int KW = $clog2(VERTEX_SLOTS + 1);
    localparam int EW = $bits(uvc_pkg::entry_t);
    localparam int RW = $bits(uvc_pkg::result_t);

    // table memory and its read register
    logic [EW-1:0] table_mem [VERTEX_SLOTS];
    logic [EW-1:0] rdata_reg;

    // clearing pass after reset
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    // update stage
    logic                      s1_valid_reg;
    uvc_pkg::cmd_t             s1_cmd_reg;
    logic [uvc_pkg::VIDX_W-1:0] s1_vidx_reg;

    // write-back forwarding
    logic                   fwd_valid_reg;
    logic [AW-1:0]          fwd_addr_reg;
    uvc_pkg::entry_t        fwd_data_reg;

    // kept counter and output register
    logic [KW-1:0]          kept_count_reg;
    logic [KW-1:0]          kept_count_next;
    logic                   out_valid_reg;
    uvc_pkg::result_t       out_data_reg;

    logic                   accept;
    logic                   s1_adv;
    logic [AW-1:0]          s1_addr;
    logic                   in_range;
    uvc_pkg::entry_t        entry;
    uvc_pkg::entry_t        entry_new;
    logic                   entry_we;
    uvc_pkg::result_t       result;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [EW-1:0]          mem_wdata;
    logic [AW-1:0]          mem_raddr;

    // handshake
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    assign mem_raddr = s_tdata[uvc_pkg::CMD_W +: AW];
    assign s1_addr   = s1_vidx_reg[AW-1:0];
    assign in_range  = {1'b0, s1_vidx_reg} < (uvc_pkg::VIDX_W + 1)'(VERTEX_SLOTS);

    // newest copy of the entry: forwarded write or memory data
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr))
        begin
            entry = fwd_data_reg;
        end
        else
        begin
            entry = uvc_pkg::entry_t'(rdata_reg);
        end
    end

    // command decode and entry update
    always_comb
    begin
        result          = '0;
        entry_new       = entry;
        entry_we        = 1'b0;
        kept_count_next = kept_count_reg;
        unique case (s1_cmd_reg)
            uvc_pkg::CMD_START:
            begin
                kept_count_next = '0;
            end
            uvc_pkg::CMD_MARK:
            begin
                if (!in_range)
                begin
                    result.status = 1'b1;
                end
                else
                begin
                    entry_new.mark = 1'b1;
                    entry_we       = 1'b1;
                end
            end
            uvc_pkg::CMD_COMPACT:
            begin
                if (!in_range)
                begin
                    result.status = 1'b1;
                end
                else if (entry.mark)
                begin
                    if (kept_count_reg >= KW'(VERTEX_SLOTS))
                    begin
                        result.status = 1'b1;
                    end
                    else
                    begin
                        result.new_index   = uvc_pkg::NIDX_W'(kept_count_reg);
                        result.move_needed = (32'(kept_count_reg) != 32'(s1_vidx_reg));
                        entry_new.mark     = 1'b0;
                        entry_new.dropped  = 1'b0;
                        entry_new.idx      = uvc_pkg::NIDX_W'(kept_count_reg);
                        entry_we           = 1'b1;
                        kept_count_next    = kept_count_reg + KW'(1);
                    end
                end
                else
                begin
                    entry_new.mark     = 1'b0;
                    entry_new.dropped  = 1'b1;
                    entry_new.idx      = '0;
                    entry_we           = 1'b1;
                    result.index_unused = 1'b1;
                end
            end
            uvc_pkg::CMD_REMAP:
            begin
                if (!in_range)
                begin
                    result.status = 1'b1;
                end
                else if (entry.dropped)
                begin
                    result.index_unused = 1'b1;
                end
                else
                begin
                    result.new_index = entry.idx;
                end
            end
        endcase
        result.kept_total = uvc_pkg::TOTAL_W'(kept_count_next);
    end

    // memory write port: clearing pass or write-back
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s1_adv && entry_we;
            mem_waddr = s1_addr;
            mem_wdata = EW'(entry_new);
        end
    end

    // table memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rdata_reg <= table_mem[mem_raddr];
        end
    end

    // clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == AW'(VERTEX_SLOTS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // update stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            kept_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                kept_count_reg <= kept_count_next;
                out_valid_reg  <= 1'b1;
                if (entry_we)
                begin
                    fwd_valid_reg <= 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // update stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= uvc_pkg::cmd_t'(s_tdata[uvc_pkg::CMD_W-1:0]);
            s1_vidx_reg <= s_tdata[uvc_pkg::CMD_W +: uvc_pkg::VIDX_W];
        end
        if (s1_adv)
        begin
            out_data_reg <= result;
            if (entry_we)
            begin
                fwd_addr_reg <= s1_addr;
                fwd_data_reg <= entry_new;
            end
        end
    end

    // result port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(uvc_pkg::OUT_TDATA_W - RW)'(0), out_data_reg};

    // no request taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_tready)
        else $error("request accepted during clearing pass");

    // kept counter never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(kept_count_reg) <= VERTEX_SLOTS)
        else $error("kept counter beyond table size");

    // a start request yields a cleared kept total
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_cmd_reg == uvc_pkg::CMD_START))
        |=> (out_data_reg.kept_total == '0) && (kept_count_reg == '0))
        else $error("start did not clear kept counter");

    // a moved vertex is never reported as dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.move_needed)
        |-> (!out_data_reg.index_unused && !out_data_reg.status))
        else $error("move flagged on dropped or failed vertex");

endmodule

`default_nettype wire
